// ===== sv/gcrl_pkg.sv =====
// ----------------------------------------------------------------------------
// gcrl_pkg
// Shared types, codes and constants of the gripper command rate limiter.
// ----------------------------------------------------------------------------
package gcrl_pkg;

  localparam int SETPOINT_BITS_DEF = 16;
  localparam int TIME_BITS_DEF     = 32;

  localparam int PIPE_STAGES    = 8;
  localparam int CLOSURE_BITS   = 16;
  localparam int SCALE_BITS     = 14;
  localparam int PERIOD_BITS    = 16;
  localparam int DEADBAND_BITS  = 16;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [SCALE_BITS-1:0] FULL_SCALE   = 14'd10000;
  localparam logic [SCALE_BITS-1:0] HALF_SCALE   = 14'd5000;
  localparam logic [SCALE_BITS-1:0] OPEN_LIMIT   = 14'd500;
  localparam logic [SCALE_BITS-1:0] CLOSED_LIMIT = 14'd9500;

  typedef enum logic [1:0] {
    KIND_OPEN    = 2'd0,
    KIND_CLOSE   = 2'd1,
    KIND_CLOSURE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_SENT          = 2'd0,
    STATUS_SKIPPED       = 2'd1,
    STATUS_NOT_CONNECTED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    GRIP_UNKNOWN = 2'd0,
    GRIP_OPEN    = 2'd1,
    GRIP_CLOSED  = 2'd2
  } grip_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_OPEN_POSITION    = 3'd0,
    REG_CLOSE_POSITION   = 3'd1,
    REG_OPEN_DEFLECTION  = 3'd2,
    REG_CLOSE_DEFLECTION = 3'd3,
    REG_MIN_PERIOD       = 3'd4,
    REG_DEADBAND         = 3'd5,
    REG_LINK_UP          = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic mul;
    logic mag;
    logic part;
    logic quot;
    logic fix;
    logic fin;
  } interp_ld_t;

endpackage

// ===== sv/gcrl_if.sv =====
// ----------------------------------------------------------------------------
// gcrl_if
// Valid/ready channels of the gripper command rate limiter.
// ----------------------------------------------------------------------------
interface gcrl_cmd_if #(
  parameter int TIME_BITS = gcrl_pkg::TIME_BITS_DEF
);
  import gcrl_pkg::*;

  logic                           valid;
  logic                           ready;
  logic [1:0]                     kind;
  logic signed [CLOSURE_BITS-1:0] closure_centi;
  logic [TIME_BITS-1:0]           now_ms;

  modport source (output valid, kind, closure_centi, now_ms, input ready);
  modport sink   (input valid, kind, closure_centi, now_ms, output ready);
endinterface

interface gcrl_res_if #(
  parameter int SETPOINT_BITS = gcrl_pkg::SETPOINT_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic [1:0]                      status;
  logic signed [SETPOINT_BITS-1:0] position_out;
  logic signed [SETPOINT_BITS-1:0] deflection_out;
  logic [1:0]                      grip_state;

  modport source (output valid, status, position_out, deflection_out, grip_state,
                  input ready);
  modport sink   (input valid, status, position_out, deflection_out, grip_state,
                  output ready);
endinterface

// ===== sv/gcrl_interp.sv =====
// ----------------------------------------------------------------------------
// gcrl_interp
// Pipelined interpolation between two setpoints with rounding half away
// from zero; the division by full scale uses a reciprocal multiply.
// ----------------------------------------------------------------------------
module gcrl_interp #(
  parameter int SETPOINT_BITS = gcrl_pkg::SETPOINT_BITS_DEF
) (
  input  logic                                clk,
  input  gcrl_pkg::interp_ld_t                ld,
  input  logic signed [SETPOINT_BITS-1:0]     lo,
  input  logic signed [SETPOINT_BITS-1:0]     hi,
  input  logic [gcrl_pkg::SCALE_BITS-1:0]     frac,
  output logic signed [SETPOINT_BITS-1:0]     value
);
  import gcrl_pkg::*;

  localparam int KW = SETPOINT_BITS + SCALE_BITS;
  localparam int NW = KW + 1;
  localparam int MW = KW - SCALE_BITS + 1;
  localparam int LW = KW / 2;
  localparam int HW = KW - LW;
  localparam logic [63:0]   RECIP_FULL = (64'd1 << KW) / 64'(FULL_SCALE);
  localparam logic [MW-1:0] RECIP      = MW'(RECIP_FULL);

  logic signed [KW-1:0]            base;
  logic signed [SETPOINT_BITS:0]   diff;
  logic signed [KW-1:0]            lo_ext;
  logic signed [KW-1:0]            scale_ext;
  logic signed [SCALE_BITS:0]      frac_s;
  logic signed [NW-1:0]            n;
  logic [NW-1:0]                   n_abs;
  logic [KW-1:0]                   mag;
  logic                            neg;
  logic [LW+MW-1:0]                p_lo;
  logic [HW+MW-1:0]                p_hi;
  logic [KW-1:0]                   mag_p;
  logic                            neg_p;
  logic [KW+MW-1:0]                prod;
  logic [MW-1:0]                   q0;
  logic [KW-1:0]                   mag_q;
  logic                            neg_q;
  logic [KW-1:0]                   rem;
  logic [MW-1:0]                   q1;
  logic                            up;
  logic                            neg_f;
  logic [MW-1:0]                   q_fin;
  logic [MW-1:0]                   q_signed;

  assign lo_ext    = KW'(lo);
  assign scale_ext = KW'($signed({1'b0, FULL_SCALE}));
  assign frac_s    = $signed({1'b0, frac});

  // config-derived terms, stable while items are in flight
  always_ff @(posedge clk) begin
    base <= lo_ext * scale_ext;
    diff <= {hi[SETPOINT_BITS-1], hi} - {lo[SETPOINT_BITS-1], lo};
  end

  assign n_abs    = n[NW-1] ? NW'(-n) : NW'(n);
  assign prod     = {p_hi, {LW{1'b0}}} + (KW+MW)'(p_lo);
  assign rem      = mag_q - KW'(q0) * KW'(FULL_SCALE);
  assign q_fin    = q1 + MW'(up);
  assign q_signed = neg_f ? (~q_fin + MW'(1)) : q_fin;

  always_ff @(posedge clk) begin
    if (ld.mul) begin
      n <= NW'(base) + NW'(frac_s) * NW'(diff);
    end
    if (ld.mag) begin
      neg <= n[NW-1];
      mag <= n_abs[KW-1:0] + KW'(HALF_SCALE);
    end
    if (ld.part) begin
      p_lo  <= mag[LW-1:0] * RECIP;
      p_hi  <= mag[KW-1:LW] * RECIP;
      mag_p <= mag;
      neg_p <= neg;
    end
    if (ld.quot) begin
      q0    <= prod[KW+MW-1:KW];
      mag_q <= mag_p;
      neg_q <= neg_p;
    end
    if (ld.fix) begin
      q1    <= q0;
      up    <= rem >= KW'(FULL_SCALE);
      neg_f <= neg_q;
    end
    if (ld.fin) begin
      value <= q_signed[SETPOINT_BITS-1:0];
    end
  end

endmodule

// ===== sv/gripper_command_rate_limiter_core.sv =====
// ----------------------------------------------------------------------------
// gripper_command_rate_limiter_core
// Gripper command setpoint generation with minimum period and deadband gate.
// ----------------------------------------------------------------------------
// cmd carries one command word (kind, closure_centi, now_ms) per handshake;
// res returns one result word (status, position_out, deflection_out,
// grip_state) for every command, in order.
// The user must write registers through cfg_we / cfg_index / cfg_data
// only while no command is in flight; the core does not enforce this.
// An index outside the list is ignored. A new command is accepted every
// cycle while res does not stall. A result passes through the input
// register, the six register stages of the interpolation path (product,
// magnitude, reciprocal partial products, quotient, remainder correction,
// sign) and the gate/output register, eight stages in all.
// When res stalls, each stage holds and empty stages close up, so cmd keeps
// accepting until all eight stages are full; nothing is dropped.
// Reset (rst, synchronous) clears the configuration registers and the stage
// valid bits, takes the link down, forgets the last sent command and sets the grip state to unknown.
// ----------------------------------------------------------------------------
module gripper_command_rate_limiter_core #(
  parameter int SETPOINT_BITS = gcrl_pkg::SETPOINT_BITS_DEF,
  parameter int TIME_BITS     = gcrl_pkg::TIME_BITS_DEF,
  localparam int CFG_BITS = (SETPOINT_BITS > gcrl_pkg::PERIOD_BITS) ?
                            SETPOINT_BITS : gcrl_pkg::PERIOD_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  gcrl_cmd_if.sink                            cmd,
  gcrl_res_if.source                          res,
  input  logic                                cfg_we,
  input  logic [gcrl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]                 cfg_data
);
  import gcrl_pkg::*;

  localparam int LAST = PIPE_STAGES - 1;
  localparam int DW   = (SETPOINT_BITS + 1 > DEADBAND_BITS) ?
                        SETPOINT_BITS + 1 : DEADBAND_BITS;

  typedef struct packed {
    logic                 ignore;
    grip_t                tgt;
    logic [TIME_BITS-1:0] now;
  } side_t;

  // configuration
  logic signed [SETPOINT_BITS-1:0] open_position;
  logic signed [SETPOINT_BITS-1:0] close_position;
  logic signed [SETPOINT_BITS-1:0] open_deflection;
  logic signed [SETPOINT_BITS-1:0] close_deflection;
  logic [PERIOD_BITS-1:0]          min_period_ms;
  logic [DEADBAND_BITS-1:0]        deadband;
  logic                            link_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_position    <= '0;
      close_position   <= '0;
      open_deflection  <= '0;
      close_deflection <= '0;
      min_period_ms    <= '0;
      deadband         <= '0;
      link_up          <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OPEN_POSITION:    open_position    <= cfg_data[SETPOINT_BITS-1:0];
        REG_CLOSE_POSITION:   close_position   <= cfg_data[SETPOINT_BITS-1:0];
        REG_OPEN_DEFLECTION:  open_deflection  <= cfg_data[SETPOINT_BITS-1:0];
        REG_CLOSE_DEFLECTION: close_deflection <= cfg_data[SETPOINT_BITS-1:0];
        REG_MIN_PERIOD:       min_period_ms    <= cfg_data[PERIOD_BITS-1:0];
        REG_DEADBAND:         deadband         <= cfg_data[DEADBAND_BITS-1:0];
        REG_LINK_UP:          link_up          <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline flow control, empty stages close up under stall
  logic [PIPE_STAGES-1:0] v;
  logic [PIPE_STAGES-1:0] rdy;
  logic [PIPE_STAGES-1:0] up_v;
  logic [PIPE_STAGES-1:0] ld;

  always_comb begin
    rdy[LAST] = !v[LAST] || res.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign up_v      = {v[LAST-1:0], cmd.valid};
  assign ld        = rdy & up_v;
  assign cmd.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (rdy & up_v) | (~rdy & v);
    end
  end

  // input register
  logic [1:0]                     kind;
  logic signed [CLOSURE_BITS-1:0] closure;
  logic [TIME_BITS-1:0]           now;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      kind    <= cmd.kind;
      closure <= cmd.closure_centi;
      now     <= cmd.now_ms;
    end
  end

  // command decode and closure clamp
  logic [SCALE_BITS-1:0] frac;
  logic [SCALE_BITS-1:0] clamped;
  side_t                 side_in;

  always_comb begin
    if (closure < 0) begin
      clamped = '0;
    end else if (closure > $signed(CLOSURE_BITS'(FULL_SCALE))) begin
      clamped = FULL_SCALE;
    end else begin
      clamped = closure[SCALE_BITS-1:0];
    end
    side_in.now    = now;
    side_in.ignore = 1'b0;
    unique case (kind)
      KIND_OPEN: begin
        frac        = '0;
        side_in.tgt = GRIP_OPEN;
      end
      KIND_CLOSE: begin
        frac        = FULL_SCALE;
        side_in.tgt = GRIP_CLOSED;
      end
      KIND_CLOSURE: begin
        frac = clamped;
        // unknown here means keep the current grip state
        if (clamped < OPEN_LIMIT) begin
          side_in.tgt = GRIP_OPEN;
        end else if (clamped > CLOSED_LIMIT) begin
          side_in.tgt = GRIP_CLOSED;
        end else begin
          side_in.tgt = GRIP_UNKNOWN;
        end
      end
      default: begin
        frac           = '0;
        side_in.tgt    = GRIP_UNKNOWN;
        side_in.ignore = 1'b1;
      end
    endcase
  end

  side_t side [1:LAST-1];

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      side[1] <= side_in;
    end
    for (int k = 2; k < LAST; k++) begin
      if (ld[k]) begin
        side[k] <= side[k-1];
      end
    end
  end

  // setpoint interpolation
  interp_ld_t                      ild;
  logic signed [SETPOINT_BITS-1:0] pos;
  logic signed [SETPOINT_BITS-1:0] def;

  assign ild = '{mul: ld[1], mag: ld[2], part: ld[3], quot: ld[4], fix: ld[5],
                 fin: ld[6]};

  gcrl_interp #(.SETPOINT_BITS(SETPOINT_BITS)) u_pos (
    .clk   (clk),
    .ld    (ild),
    .lo    (open_position),
    .hi    (close_position),
    .frac  (frac),
    .value (pos)
  );

  gcrl_interp #(.SETPOINT_BITS(SETPOINT_BITS)) u_def (
    .clk   (clk),
    .ld    (ild),
    .lo    (open_deflection),
    .hi    (close_deflection),
    .frac  (frac),
    .value (def)
  );

  // gate and history
  logic                            have_sent;
  logic [TIME_BITS-1:0]            last_time;
  logic signed [SETPOINT_BITS-1:0] last_pos;
  logic signed [SETPOINT_BITS-1:0] last_def;
  grip_t                           grip_mode;

  side_t                       s6;
  logic [TIME_BITS-1:0]        dt;
  logic signed [SETPOINT_BITS:0] dp;
  logic signed [SETPOINT_BITS:0] dd;
  logic [SETPOINT_BITS:0]      dp_mag;
  logic [SETPOINT_BITS:0]      dd_mag;
  logic                        period_hit;
  logic                        near;
  logic                        send;
  status_t                     status_next;
  grip_t                       grip_next;

  assign s6         = side[LAST-1];
  assign dt         = s6.now - last_time;
  assign period_hit = have_sent && (min_period_ms != '0) &&
                      (dt < TIME_BITS'(min_period_ms));
  assign dp         = {pos[SETPOINT_BITS-1], pos} - {last_pos[SETPOINT_BITS-1], last_pos};
  assign dd         = {def[SETPOINT_BITS-1], def} - {last_def[SETPOINT_BITS-1], last_def};
  assign dp_mag     = dp[SETPOINT_BITS] ? (~dp + 1'b1) : dp;
  assign dd_mag     = dd[SETPOINT_BITS] ? (~dd + 1'b1) : dd;
  assign near       = have_sent && (deadband != '0) &&
                      (DW'(dp_mag) < DW'(deadband)) && (DW'(dd_mag) < DW'(deadband));

  always_comb begin
    grip_next = (s6.tgt == GRIP_UNKNOWN) ? grip_mode : s6.tgt;
    send      = 1'b0;
    if (s6.ignore) begin
      status_next = STATUS_SKIPPED;
      grip_next   = grip_mode;
    end else if (!link_up) begin
      status_next = STATUS_NOT_CONNECTED;
    end else if (period_hit || near) begin
      status_next = STATUS_SKIPPED;
    end else begin
      status_next = STATUS_SENT;
      send        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_sent <= 1'b0;
      last_time <= '0;
      last_pos  <= '1;
      last_def  <= '0;
      grip_mode <= GRIP_UNKNOWN;
    end else if (ld[LAST]) begin
      grip_mode <= grip_next;
      if (send) begin
        have_sent <= 1'b1;
        last_time <= s6.now;
        last_pos  <= pos;
        last_def  <= def;
      end
    end
  end

  // result register
  status_t                         status;
  logic signed [SETPOINT_BITS-1:0] position_out;
  logic signed [SETPOINT_BITS-1:0] deflection_out;
  grip_t                           grip_state;

  always_ff @(posedge clk) begin
    if (ld[LAST]) begin
      status         <= status_next;
      position_out   <= s6.ignore ? '0 : pos;
      deflection_out <= s6.ignore ? '0 : def;
      grip_state     <= grip_next;
    end
  end

  assign res.valid          = v[LAST];
  assign res.status         = status;
  assign res.position_out   = position_out;
  assign res.deflection_out = deflection_out;
  assign res.grip_state     = grip_state;

endmodule

// ===== sv/gcrl_checker.sv =====
// ----------------------------------------------------------------------------
// gcrl_checker
// Port-level checks of the gripper command rate limiter, bound to the core.
// ----------------------------------------------------------------------------
module gcrl_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] res_status,
  input logic [1:0] res_grip
);
  import gcrl_pkg::*;

  localparam int CNT_BITS = $clog2(PIPE_STAGES + 1);

  logic [CNT_BITS-1:0] inflight;

  // words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CNT_BITS'(cmd_valid && cmd_ready)
                           - CNT_BITS'(res_valid && res_ready);
    end
  end

  a_reset_clears_result: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_no_result_without_cmd: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> inflight != '0)
    else $error("result word without an accepted command");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    inflight <= CNT_BITS'(PIPE_STAGES))
    else $error("more words in flight than pipeline stages");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    inflight == '0 |-> cmd_ready)
    else $error("command not accepted while pipeline empty");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_grip))
    else $error("stalled result word changed");

endmodule

bind gripper_command_rate_limiter_core gcrl_checker u_gcrl_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .res_status (res.status),
  .res_grip   (res.grip_state)
);
